// File: sv/sacl_pkg.sv
`default_nettype none
package sacl_pkg;

   localparam int NUM_SETS       = 128;
   localparam int NUM_WAYS       = 8;
   localparam int WORDS_PER_LINE = 32;

   localparam int ADDR_W = 32;
   localparam int WORD_W = 32;
   localparam int OFF_W  = $clog2(WORDS_PER_LINE);
   localparam int SET_W  = $clog2(NUM_SETS);
   localparam int WAY_W  = $clog2(NUM_WAYS);
   localparam int AGE_W  = $clog2(NUM_WAYS);
   localparam int TAG_W  = ADDR_W - OFF_W - SET_W;

   localparam int DATA_DEPTH  = NUM_SETS * NUM_WAYS * WORDS_PER_LINE;
   localparam int DATA_ADDR_W = SET_W + WAY_W + OFF_W;

   localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(NUM_WAYS - 1);

   typedef enum logic {
      KIND_READ  = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   typedef struct packed {
      logic [NUM_WAYS-1:0][TAG_W-1:0] tag;
      logic [NUM_WAYS-1:0]            valid;
      logic [NUM_WAYS-1:0][AGE_W-1:0] age;
   } meta_row_type;

   typedef struct packed {
      logic             en;
      logic [SET_W-1:0] addr;
      meta_row_type     row;
   } meta_wr_type;

   typedef struct packed {
      logic                   we;
      logic                   re;
      logic [DATA_ADDR_W-1:0] addr;
      logic [WORD_W-1:0]      wdata;
   } data_req_type;

   // row content after reset: nothing valid, age of each way equals its index
   function automatic meta_row_type reset_row(input logic [NUM_WAYS-1:0][TAG_W-1:0] tags);
      meta_row_type r;
      r.tag   = tags;
      r.valid = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         r.age[w] = AGE_W'(w);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/sacl_if.sv
`default_nettype none
interface sacl_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [sacl_pkg::ADDR_W-1:0] address;
   logic [sacl_pkg::WORD_W-1:0] write_data;
   logic [sacl_pkg::WORD_W-1:0] fill_data;

   modport source (output valid, kind, address, write_data, fill_data, input ready);
   modport sink   (input valid, kind, address, write_data, fill_data, output ready);
endinterface

interface sacl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        done_kind;
   logic                        hit;
   logic [sacl_pkg::WORD_W-1:0] read_data;

   modport source (output valid, done_kind, hit, read_data, input ready);
   modport sink   (input valid, done_kind, hit, read_data, output ready);
endinterface
`default_nettype wire

// File: sv/sacl_meta_ram.sv
`default_nettype none
module sacl_meta_ram
   import sacl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rd_en,
   input  wire logic [SET_W-1:0] rd_addr,
   output meta_row_type      rd_row,
   input  wire meta_wr_type  wr
);

   meta_row_type        mem [NUM_SETS];
   meta_row_type        rd_data_ff;
   logic [NUM_SETS-1:0] row_valid_ff;
   logic                rd_row_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.row;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // a row never written since reset reads as the reset row
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff    <= '0;
         rd_row_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            row_valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_row_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_row = rd_row_valid_ff ? rd_data_ff : reset_row(rd_data_ff.tag);

endmodule
`default_nettype wire

// File: sv/sacl_data_ram.sv
`default_nettype none
module sacl_data_ram
   import sacl_pkg::*;
(
   input  wire logic              clock,
   input  wire data_req_type      req,
   output logic [WORD_W-1:0]      rd_data
);

   logic [WORD_W-1:0] mem [DATA_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.re) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/sacl_lru.sv
`default_nettype none
module sacl_lru
   import sacl_pkg::*;
(
   input  wire meta_row_type     row,
   input  wire logic [TAG_W-1:0] tag,
   output logic                  hit,
   output logic [WAY_W-1:0]      way,
   output meta_row_type          new_row
);

   logic [WAY_W-1:0] hit_way;
   logic [WAY_W-1:0] victim;
   logic [AGE_W-1:0] cur_age;

   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      victim  = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (row.valid[w] && row.tag[w] == tag) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         // ages form a permutation, so exactly one way holds the oldest age
         if (row.age[w] == AGE_OLDEST) begin
            victim = WAY_W'(w);
         end
      end
      way = hit ? hit_way : victim;
   end

   always_comb begin
      cur_age = row.age[way];
      new_row = row;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (row.age[w] < cur_age) begin
            new_row.age[w] = row.age[w] + AGE_W'(1);
         end
      end
      new_row.age[way] = '0;
      if (!hit) begin
         new_row.tag[way]   = tag;
         new_row.valid[way] = 1'b1;
      end
   end

endmodule
`default_nettype wire

// File: sv/set_assoc_cache_lru.sv
// 8-way, 128-set cache with true LRU replacement, 32-word lines.
// req channel: one access item (kind, address, write_data, fill_data).
// rsp channel: one item per access (done_kind, hit, read_data), in order.
// Each item walks three steps: set row read from the tag/valid/age RAM,
// tag compare + LRU update + row write-back with the data RAM access,
// then the result (data RAM read word, fill data or zero) lands in the output register.
// A new item is accepted only in ST_IDLE or in ST_FIN of the previous
// item, as required by the read-modify-write of the set row RAM
// followed by the dependent data RAM access.
// The output register lets the next item be accepted in the same cycle
// the previous result is taken. If rsp is stalled, the block holds its
// finished item and stops taking new ones until the output frees up.
// Reset clears the per-set row flags at once, then sweeps the data RAM
// to zero, one word a cycle, with req.ready low until all 32768 words are written.
`default_nettype none
module set_assoc_cache_lru
   import sacl_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   sacl_req_if.sink   req,
   sacl_rsp_if.source rsp
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_LOOK  = 4'b0100,
      ST_FIN   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [DATA_ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic              kind_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [SET_W-1:0]  set_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [WORD_W-1:0] wdata_ff;
   logic [WORD_W-1:0] fdata_ff;

   logic              use_mem_ff;
   logic              hit_ff;
   logic [WORD_W-1:0] alt_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff;
   logic              rsp_hit_ff;
   logic [WORD_W-1:0] rsp_data_ff;

   logic accept;
   logic out_free;
   logic load_out;

   meta_row_type     rd_row;
   meta_wr_type      meta_wr;
   data_req_type     data_req;
   logic [WORD_W-1:0] mem_rdata;
   logic             lru_hit;
   logic [WAY_W-1:0] lru_way;
   meta_row_type     lru_row;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) || (state_ff == ST_FIN && out_free);
   assign accept    = req.valid && req.ready;
   assign load_out  = (state_ff == ST_FIN) && out_free;

   sacl_meta_ram u_meta (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req.address[OFF_W +: SET_W]),
      .rd_row  (rd_row),
      .wr      (meta_wr)
   );

   sacl_lru u_lru (
      .row     (rd_row),
      .tag     (tag_ff),
      .hit     (lru_hit),
      .way     (lru_way),
      .new_row (lru_row)
   );

   sacl_data_ram u_data (
      .clock   (clock),
      .req     (data_req),
      .rd_data (mem_rdata)
   );

   always_comb begin
      meta_wr.en   = (state_ff == ST_LOOK);
      meta_wr.addr = set_ff;
      meta_wr.row  = lru_row;
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         data_req.we    = 1'b1;
         data_req.re    = 1'b0;
         data_req.addr  = clr_cnt_ff;
         data_req.wdata = '0;
      end else begin
         // writes and read misses store a word; only a read hit reads one
         data_req.we    = (state_ff == ST_LOOK) && (kind_ff == KIND_WRITE || !lru_hit);
         data_req.re    = (state_ff == ST_LOOK) && kind_ff == KIND_READ && lru_hit;
         data_req.addr  = {set_ff, lru_way, off_ff};
         data_req.wdata = (kind_ff == KIND_WRITE) ? wdata_ff : fdata_ff;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + DATA_ADDR_W'(1);
            if (clr_cnt_ff == DATA_ADDR_W'(DATA_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (accept) begin
               state_in = ST_LOOK;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req.kind;
         tag_ff   <= req.address[ADDR_W-1 -: TAG_W];
         set_ff   <= req.address[OFF_W +: SET_W];
         off_ff   <= req.address[OFF_W-1:0];
         wdata_ff <= req.write_data;
         fdata_ff <= req.fill_data;
      end
      if (state_ff == ST_LOOK) begin
         hit_ff      <= lru_hit;
         use_mem_ff  <= (kind_ff == KIND_READ) && lru_hit;
         alt_data_ff <= (kind_ff == KIND_WRITE) ? '0 : fdata_ff;
      end
      if (load_out) begin
         rsp_kind_ff <= kind_ff;
         rsp_hit_ff  <= hit_ff;
         rsp_data_ff <= use_mem_ff ? mem_rdata : alt_data_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.done_kind = rsp_kind_ff;
   assign rsp.hit       = rsp_hit_ff;
   assign rsp.read_data = rsp_data_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req.ready)
      else $error("item accepted during data RAM clear");

   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOK)
      else $error("accepted item did not enter lookup");

   a_data_read_on_read_hit: assert property (@(posedge clock) disable iff (reset)
      data_req.re |-> (lru_hit && kind_ff == KIND_READ && !data_req.we))
      else $error("data RAM read outside a read hit");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      load_out |=> rsp.valid)
      else $error("finished item not presented on rsp");

endmodule
`default_nettype wire
